// ===== rtl/cfd_pkg.sv =====
// Shared types and constants for the chat frame deframer.
// Holds character codes, class and status codes and the result type.
// No dependencies.
`default_nettype none

package cfd_pkg;

   localparam logic [7:0]  BarChar     = 8'h7C;
   localparam logic [7:0]  VersionChar = 8'h31;
   localparam logic [7:0]  DigitZero   = 8'h30;
   localparam logic [7:0]  DigitNine   = 8'h39;
   localparam logic [16:0] LenCap      = 17'd99999;

   localparam logic [23:0] CodeNam = 24'h4E414D;
   localparam logic [23:0] CodeSet = 24'h534554;
   localparam logic [23:0] CodeMsg = 24'h4D5347;
   localparam logic [23:0] CodeWho = 24'h57484F;

   typedef enum logic {
      KIND_BYTE    = 1'b0,
      KIND_VERDICT = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      CLS_NAM   = 3'd0,
      CLS_SET   = 3'd1,
      CLS_MSG   = 3'd2,
      CLS_WHO   = 3'd3,
      CLS_OTHER = 3'd4
   } class_type;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_BAD_HEADER   = 3'd1,
      ST_BAD_END      = 3'd2,
      ST_UNKNOWN_CODE = 3'd3,
      ST_FEW_FIELDS   = 3'd4
   } status_type;

   typedef struct packed {
      kind_type    item_kind;
      status_type  status;
      logic [16:0] body_length;
      class_type   code_class;
      logic [1:0]  field_index;
      logic [7:0]  data_byte;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/cfd_parser.sv =====
// Byte-serial frame parser: header, length, body count-out and verdict.
// Depends on cfd_pkg for character codes and the result type.
`default_nettype none

module cfd_parser (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               byte_valid,
   input  wire logic [7:0]         byte_data,
   input  wire logic [16:0]        max_len,
   output logic                    res_valid,
   output cfd_pkg::result_type     res
);

   typedef enum logic [1:0] {
      PH_VERSION,
      PH_CODE,
      PH_LENGTH,
      PH_BODY
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic        version_good_ff, version_good_in;
   logic [1:0]  version_count_ff, version_count_in;
   logic [23:0] code_chars_ff, code_chars_in;
   logic [2:0]  code_count_ff, code_count_in;
   logic [16:0] length_accum_ff, length_accum_in;
   logic        length_bad_ff, length_bad_in;
   logic        digit_seen_ff, digit_seen_in;
   logic [16:0] bytes_left_ff, bytes_left_in;
   logic [1:0]  bars_ff, bars_in;
   logic        stopped_ff, stopped_in;

   cfd_pkg::class_type  cls;
   cfd_pkg::status_type end_status;
   logic [16:0] limit;
   logic [19:0] length_next;
   logic        is_bar;
   logic        is_digit;
   logic        hdr_good;

   always_comb begin
      if (code_count_ff != 3'd3) begin
         cls = cfd_pkg::CLS_OTHER;
      end else begin
         case (code_chars_ff)
            cfd_pkg::CodeNam: cls = cfd_pkg::CLS_NAM;
            cfd_pkg::CodeSet: cls = cfd_pkg::CLS_SET;
            cfd_pkg::CodeMsg: cls = cfd_pkg::CLS_MSG;
            cfd_pkg::CodeWho: cls = cfd_pkg::CLS_WHO;
            default:          cls = cfd_pkg::CLS_OTHER;
         endcase
      end
   end

   assign is_bar    = (byte_data == cfd_pkg::BarChar);
   assign is_digit  = (byte_data >= cfd_pkg::DigitZero) && (byte_data <= cfd_pkg::DigitNine);
   assign limit     = (max_len < cfd_pkg::LenCap) ? max_len : cfd_pkg::LenCap;
   // accum * 10 + digit as shift-add
   assign length_next = {length_accum_ff, 3'b000} + {2'b00, length_accum_ff, 1'b0}
                      + {16'd0, byte_data[3:0]};
   assign hdr_good  = (version_count_ff == 2'd1) && version_good_ff && digit_seen_ff
                    && !length_bad_ff;

   always_comb begin
      if (!is_bar) begin
         end_status = cfd_pkg::ST_BAD_END;
      end else if (cls == cfd_pkg::CLS_OTHER) begin
         end_status = cfd_pkg::ST_UNKNOWN_CODE;
      end else if (cls == cfd_pkg::CLS_MSG && bars_ff < 2'd2) begin
         end_status = cfd_pkg::ST_FEW_FIELDS;
      end else begin
         end_status = cfd_pkg::ST_OK;
      end
   end

   always_comb begin
      phase_in         = phase_ff;
      version_good_in  = version_good_ff;
      version_count_in = version_count_ff;
      code_chars_in    = code_chars_ff;
      code_count_in    = code_count_ff;
      length_accum_in  = length_accum_ff;
      length_bad_in    = length_bad_ff;
      digit_seen_in    = digit_seen_ff;
      bytes_left_in    = bytes_left_ff;
      bars_in          = bars_ff;
      stopped_in       = stopped_ff;
      res_valid        = 1'b0;
      res.item_kind    = cfd_pkg::KIND_VERDICT;
      res.status       = cfd_pkg::ST_OK;
      res.body_length  = 17'd0;
      res.code_class   = cls;
      res.field_index  = 2'd0;
      res.data_byte    = 8'd0;

      if (byte_valid && !stopped_ff) begin
         case (phase_ff)
            PH_CODE: begin
               if (is_bar) begin
                  phase_in = PH_LENGTH;
               end else if (code_count_ff < 3'd3) begin
                  code_chars_in = {code_chars_ff[15:0], byte_data};
                  code_count_in = code_count_ff + 3'd1;
               end else begin
                  code_count_in = 3'd4;
               end
            end
            PH_LENGTH: begin
               if (is_bar) begin
                  if (!hdr_good || length_accum_ff == 17'd0) begin
                     res_valid  = 1'b1;
                     res.status = hdr_good ? cfd_pkg::ST_BAD_END
                                           : cfd_pkg::ST_BAD_HEADER;
                     stopped_in = 1'b1;
                  end else begin
                     bytes_left_in = length_accum_ff;
                     bars_in       = 2'd0;
                     phase_in      = PH_BODY;
                  end
               end else if (is_digit) begin
                  digit_seen_in = 1'b1;
                  if (!length_bad_ff) begin
                     if (length_next > {3'b000, limit}) begin
                        length_bad_in = 1'b1;
                     end else begin
                        length_accum_in = length_next[16:0];
                     end
                  end
               end else begin
                  length_bad_in = 1'b1;
               end
            end
            PH_BODY: begin
               if (bytes_left_ff <= 17'd1) begin
                  res_valid       = 1'b1;
                  res.status      = end_status;
                  res.body_length = length_accum_ff;
                  if (end_status != cfd_pkg::ST_OK) begin
                     stopped_in = 1'b1;
                  end
               end else begin
                  bytes_left_in = bytes_left_ff - 17'd1;
                  if (cls == cfd_pkg::CLS_MSG && is_bar && bars_ff < 2'd2) begin
                     // consume a field separator
                     bars_in = bars_ff + 2'd1;
                  end else begin
                     res_valid       = 1'b1;
                     res.item_kind   = cfd_pkg::KIND_BYTE;
                     res.body_length = length_accum_ff;
                     res.data_byte   = byte_data;
                     res.field_index = (cls == cfd_pkg::CLS_MSG) ? bars_ff : 2'd0;
                  end
               end
            end
            default: begin
               if (is_bar) begin
                  phase_in = PH_CODE;
               end else begin
                  version_good_in = (version_count_ff == 2'd0)
                                  && (byte_data == cfd_pkg::VersionChar);
                  if (version_count_ff < 2'd2) begin
                     version_count_in = version_count_ff + 2'd1;
                  end
               end
            end
         endcase

         // every verdict closes the frame: clear the frame state
         if (res_valid && res.item_kind == cfd_pkg::KIND_VERDICT) begin
            phase_in         = PH_VERSION;
            version_good_in  = 1'b0;
            version_count_in = 2'd0;
            code_chars_in    = 24'd0;
            code_count_in    = 3'd0;
            length_accum_in  = 17'd0;
            length_bad_in    = 1'b0;
            digit_seen_in    = 1'b0;
            bytes_left_in    = 17'd0;
            bars_in          = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_VERSION;
         version_good_ff  <= 1'b0;
         version_count_ff <= 2'd0;
         code_chars_ff    <= 24'd0;
         code_count_ff    <= 3'd0;
         length_accum_ff  <= 17'd0;
         length_bad_ff    <= 1'b0;
         digit_seen_ff    <= 1'b0;
         bytes_left_ff    <= 17'd0;
         bars_ff          <= 2'd0;
         stopped_ff       <= 1'b0;
      end else begin
         phase_ff         <= phase_in;
         version_good_ff  <= version_good_in;
         version_count_ff <= version_count_in;
         code_chars_ff    <= code_chars_in;
         code_count_ff    <= code_count_in;
         length_accum_ff  <= length_accum_in;
         length_bad_ff    <= length_bad_in;
         digit_seen_ff    <= digit_seen_in;
         bytes_left_ff    <= bytes_left_in;
         bars_ff          <= bars_in;
         stopped_ff       <= stopped_in;
      end
   end

   a_stopped_sticky: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |=> stopped_ff)
      else $error("parser left the stopped state without reset");

   a_stopped_silent: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |-> !res_valid)
      else $error("stopped parser produced a result");

   a_body_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_BODY) |-> (bytes_left_ff != 17'd0 && length_accum_ff != 17'd0))
      else $error("body phase with nothing to count");

endmodule

`default_nettype wire

// ===== rtl/chat_frame_deframer.sv =====
// Chat frame deframer top level: length register, parser and result skid stage.
// Depends on cfd_pkg and cfd_parser.
// A parser result is registered in the output register, or in the skid entry.
// Throughput: one byte per cycle while the skid is free; the two-entry result
// stage (output register plus skid) takes a byte while a finished result waits.
// Reset (synchronous, active high): parser at the start of a frame and running,
// result stage empty, maximum body length back to 99999.
`default_nettype none

module chat_frame_deframer (
   input  wire logic        clock,
   input  wire logic        reset,
   // input byte stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] in_byte
   // result stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [7:0] data_byte, [9:8] field_index, [12:10] code_class,
   // [29:13] body_length, [32:30] status, [39:33] zero
   output logic [39:0]      rsp_tdata,
   output logic             rsp_tuser,   // [0] item_kind
   output logic             rsp_tlast,   // frame_last
   // configuration
   input  wire logic        csr_we,
   input  wire logic [16:0] csr_wdata   // max_body_length
);

   logic                 max_len_ff;
   logic [16:0]          max_len_val_ff;
   logic                 req_fire;
   logic                 res_valid;
   cfd_pkg::result_type  res;
   logic                 out_valid_ff;
   cfd_pkg::result_type  out_ff;
   logic                 skid_valid_ff;
   cfd_pkg::result_type  skid_ff;
   logic                 rsp_fire;

   // Hold the maximum body length; the user must write it only while the block is idle (unchecked by the block).
   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_val_ff <= cfd_pkg::LenCap;
         max_len_ff     <= 1'b0;
      end else begin
         if (csr_we) begin
            max_len_val_ff <= csr_wdata;
         end
         max_len_ff <= csr_we;
      end
   end

   // Take a byte whenever the skid entry is free: the output register may
   // still hold a stalled result.
   assign req_tready = !skid_valid_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = out_valid_ff && rsp_tready;

   cfd_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_fire),
      .byte_data  (req_tdata),
      .max_len    (max_len_val_ff),
      .res_valid  (res_valid),
      .res        (res)
   );

   // Result stage: advance the skid entry first, else load a fresh result;
   // park a fresh result in the skid entry while the output stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (!out_valid_ff || rsp_fire) begin
            if (skid_valid_ff) begin
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end else begin
               out_valid_ff <= res_valid;
            end
         end else if (res_valid) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp_fire) begin
         out_ff <= skid_valid_ff ? skid_ff : res;
      end else if (res_valid) begin
         skid_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.item_kind;
   assign rsp_tlast  = (out_ff.item_kind == cfd_pkg::KIND_VERDICT);
   assign rsp_tdata  = {7'd0, out_ff.status, out_ff.body_length, out_ff.code_class,
                        out_ff.field_index, out_ff.data_byte};

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry holds a result while the output register is empty");

   a_byte_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == cfd_pkg::KIND_BYTE) |->
         (rsp_tdata[32:30] == cfd_pkg::ST_OK && rsp_tdata[9:8] != 2'd3))
      else $error("body byte transfer with a status or a bad field index");

   a_header_verdict: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[32:30] == cfd_pkg::ST_BAD_HEADER) |->
         (rsp_tdata[29:13] == 17'd0 && rsp_tdata[7:0] == 8'd0))
      else $error("bad header verdict carries a body length or data");

   a_csr_seen: assert property (@(posedge clock) disable iff (reset)
      max_len_ff |-> (max_len_val_ff == $past(csr_wdata)))
      else $error("length register missed a write");

endmodule

`default_nettype wire

// ===== test/cfd_frame_checker.sv =====
// Scoreboard for the chat frame deframer: watches the byte, result and register
// channels, predicts every result item and compares it field by field.
// Depends on cfd_pkg for the character codes and the result type.
`default_nettype none

module cfd_frame_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [7:0]  req_tdata,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [39:0] rsp_tdata,
   input  wire logic        rsp_tuser,
   input  wire logic        rsp_tlast,
   input  wire logic        csr_we,
   input  wire logic [16:0] csr_wdata,
   output int               fail_count,
   output int               pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import cfd_pkg::*;

   typedef enum logic [1:0] {
      P_VERSION,
      P_CODE,
      P_LENGTH,
      P_BODY
   } parse_phase_type;

   // shadow of the parser and its length register
   parse_phase_type ph;
   logic            ver_ok;
   logic [1:0]      ver_cnt;
   logic [23:0]     code_sr;
   logic [2:0]      code_n;
   logic [16:0]     len_acc;
   logic            len_err;
   logic            len_any;
   logic [16:0]     remain;
   logic [1:0]      seps;
   logic            halted;
   logic [16:0]     limit_reg;

   result_type      due_items[$];

   function automatic void restart_frame();
      ph      = P_VERSION;
      ver_ok  = 1'b0;
      ver_cnt = '0;
      code_sr = '0;
      code_n  = '0;
      len_acc = '0;
      len_err = 1'b0;
      len_any = 1'b0;
      remain  = '0;
      seps    = '0;
   endfunction

   function automatic class_type classify();
      if (code_n != 3'd3) return CLS_OTHER;
      case (code_sr)
         CodeNam: return CLS_NAM;
         CodeSet: return CLS_SET;
         CodeMsg: return CLS_MSG;
         CodeWho: return CLS_WHO;
         default: return CLS_OTHER;
      endcase
   endfunction

   function automatic result_type verdict(class_type cls, logic [16:0] len, status_type st);
      result_type v;
      v             = '0;
      v.item_kind   = KIND_VERDICT;
      v.code_class  = cls;
      v.body_length = len;
      v.status      = st;
      return v;
   endfunction

   // advance the shadow parser by one byte; made says whether a result follows
   function automatic void parse_byte(input logic [7:0] b, output logic made,
                                      output result_type r);
      class_type   cls;
      status_type  st;
      logic [16:0] cap;
      logic [16:0] len;
      int          nxt;
      made = 1'b0;
      r    = '0;
      if (!halted) begin
         case (ph)
            P_VERSION: begin
               if (b == BarChar) begin
                  ph = P_CODE;
               end else begin
                  ver_ok = (ver_cnt == 2'd0) && (b == VersionChar);
                  if (ver_cnt < 2'd2) ver_cnt++;
               end
            end
            P_CODE: begin
               if (b == BarChar) begin
                  ph = P_LENGTH;
               end else if (code_n < 3'd3) begin
                  code_sr = {code_sr[15:0], b};
                  code_n++;
               end else begin
                  code_n = 3'd4;
               end
            end
            P_LENGTH: begin
               if (b == BarChar) begin
                  cls = classify();
                  if (!(ver_cnt == 2'd1 && ver_ok && len_any && !len_err)) begin
                     halted = 1'b1;
                     restart_frame();
                     made = 1'b1;
                     r    = verdict(cls, '0, ST_BAD_HEADER);
                  end else if (len_acc == '0) begin
                     halted = 1'b1;
                     restart_frame();
                     made = 1'b1;
                     r    = verdict(cls, '0, ST_BAD_END);
                  end else begin
                     remain = len_acc;
                     seps   = '0;
                     ph     = P_BODY;
                  end
               end else if (b >= DigitZero && b <= DigitNine) begin
                  len_any = 1'b1;
                  if (!len_err) begin
                     cap = (limit_reg < LenCap) ? limit_reg : LenCap;
                     nxt = int'(len_acc) * 10 + int'(b - DigitZero);
                     if (nxt > int'(cap)) len_err = 1'b1;
                     else len_acc = 17'(nxt);
                  end
               end else begin
                  len_err = 1'b1;
               end
            end
            default: begin
               cls = classify();
               len = len_acc;
               if (remain <= 17'd1) begin
                  // closing byte: bar first, then code, then MSG field count
                  if (b != BarChar) st = ST_BAD_END;
                  else if (cls == CLS_OTHER) st = ST_UNKNOWN_CODE;
                  else if (cls == CLS_MSG && seps < 2'd2) st = ST_FEW_FIELDS;
                  else st = ST_OK;
                  if (st != ST_OK) halted = 1'b1;
                  restart_frame();
                  made = 1'b1;
                  r    = verdict(cls, len, st);
               end else begin
                  remain--;
                  if (cls == CLS_MSG && b == BarChar && seps < 2'd2) begin
                     seps++;
                  end else begin
                     made          = 1'b1;
                     r.item_kind   = KIND_BYTE;
                     r.data_byte   = b;
                     r.field_index = (cls == CLS_MSG) ? seps : 2'd0;
                     r.code_class  = cls;
                     r.body_length = len;
                     r.status      = ST_OK;
                  end
               end
            end
         endcase
      end
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      result_type want;
      result_type fresh;
      logic       made;
      if (reset) begin
         limit_reg  = LenCap;
         halted     = 1'b0;
         restart_frame();
         due_items.delete();
         fail_count = 0;
      end else begin
         // compare before predicting: a result never belongs to this edge's byte
         if (rsp_tvalid && rsp_tready) begin
            if (due_items.size() == 0) begin
               $error("result with nothing expected: tdata %h, tuser %b", rsp_tdata, rsp_tuser);
               fail_count++;
            end else begin
               want = due_items.pop_front();
               check_field("item_kind", want.item_kind, rsp_tuser);
               check_field("data_byte", want.data_byte, rsp_tdata[7:0]);
               check_field("field_index", want.field_index, rsp_tdata[9:8]);
               check_field("code_class", want.code_class, rsp_tdata[12:10]);
               check_field("body_length", want.body_length, rsp_tdata[29:13]);
               check_field("status", want.status, rsp_tdata[32:30]);
               check_field("tdata padding", '0, rsp_tdata[39:33]);
               check_field("frame_last", want.item_kind, rsp_tlast);
            end
         end
         if (req_tvalid && req_tready) begin
            parse_byte(req_tdata, made, fresh);
            if (made) due_items.push_back(fresh);
         end
         // a byte at the write edge still sees the old limit
         if (csr_we) limit_reg = csr_wdata;
      end
      pending <= due_items.size();
   end

endmodule

`default_nettype wire

// ===== test/tb_chat_frame_deframer.sv =====
// Testbench top for the chat frame deframer: clock, reset, byte stimulus,
// receiver back-pressure, length register writes and the final verdict.
// Depends on cfd_pkg, chat_frame_deframer and cfd_frame_checker.
`default_nettype none

module tb_chat_frame_deframer;
   timeunit 1ns;
   timeprecision 1ps;
   import cfd_pkg::*;

   localparam int CycleLimit = 400000;
   localparam int PhaseBytes = 160;

   // ways to end the run with a frame that stops the parser
   typedef enum int {
      BRK_VERSION,
      BRK_EMPTY_LEN,
      BRK_NONDIGIT,
      BRK_OVER_LIMIT,
      BRK_ZERO_LEN,
      BRK_BAD_END,
      BRK_UNKNOWN_CODE,
      BRK_FEW_FIELDS
   } break_kind_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we     = 1'b0;
   logic [16:0] csr_wdata  = '0;

   int fail_count;
   int pending;

   // byte stream waiting to be sent, and its bookkeeping
   logic [7:0]  tx_q[$];
   int          bytes_queued = 0;
   int          bytes_sent   = 0;
   int          frames_ok    = 0;
   int          limits_used  = 0;
   logic [16:0] cur_limit    = LenCap;
   int          cycle_count  = 0;

   // sender pacing
   int burst_left = 8;
   int gap_left   = 0;

   // receiver pacing and the one long hold-off
   logic hold_go    = 1'b0;
   logic hold_done  = 1'b0;
   int   hold_left  = 0;
   int   mode_left  = 0;
   int   stall_rate = 0;

   break_kind_type brk;

   always #1ns clock = ~clock;

   chat_frame_deframer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   cfd_frame_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // Sender: offer bytes in bursts of random length, with random gaps between
   // them; now and then a long burst runs with no gap at all. Hold the byte
   // until its transfer, then advance.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            bytes_sent <= bytes_sent + 1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                         : $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
            end
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (tx_q.size() != 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= tx_q.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: alternate stretches of steady readiness with stretches of
   // random stalls; once asked, hold off for a long stretch so that the
   // result stage fills and the block stalls its input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_go && !hold_done) begin
         hold_done = 1'b1;
         hold_left = 300;
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left <= 0) begin
            mode_left  = $urandom_range(10, 80);
            stall_rate = $urandom_range(0, 3);
         end
         mode_left--;
         rsp_tready <= (stall_rate == 0) || ($urandom_range(0, 3) >= stall_rate);
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $error("watchdog expired after %0d cycles, %0d results still due",
                cycle_count, pending);
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic queue_byte(input logic [7:0] b);
      tx_q.push_back(b);
      bytes_queued++;
   endtask

   task automatic queue_text(input string s);
      for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
   endtask

   task automatic queue_code(input logic [23:0] code);
      queue_byte(code[23:16]);
      queue_byte(code[15:8]);
      queue_byte(code[7:0]);
   endtask

   // decimal length field, optionally with leading zeros
   task automatic queue_number(input int unsigned v, input int unsigned zeros);
      repeat (zeros) queue_byte(DigitZero);
      queue_text($sformatf("%0d", v));
   endtask

   function automatic logic [7:0] any_but_bar();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (b == BarChar);
      return b;
   endfunction

   function automatic logic [23:0] pick_code();
      case ($urandom_range(0, 3))
         0:       return CodeNam;
         1:       return CodeSet;
         2:       return CodeWho;
         default: return CodeMsg;
      endcase
   endfunction

   // Queue one well-formed frame. want_len of zero picks a length: mostly
   // short bodies, some medium, now and then a long one (at the limit if it is <= 400).
   task automatic queue_good_frame(input int unsigned want_len);
      int unsigned lim;
      int unsigned len;
      int unsigned r;
      int unsigned bars;
      int unsigned i;
      int unsigned j;
      logic [23:0] code;
      logic [7:0]  body[$];
      lim = (cur_limit < LenCap) ? cur_limit : LenCap;
      r   = $urandom_range(0, 19);
      if (want_len != 0) len = want_len;
      else if (r == 0) len = (lim <= 400) ? lim : $urandom_range(100, 400);
      else if (r < 5) len = $urandom_range(1, (lim < 60) ? lim : 60);
      else len = $urandom_range(1, (lim < 10) ? lim : 10);
      code = pick_code();
      // MSG needs room for two separators and the closing bar
      if (code == CodeMsg && len < 3) code = CodeWho;
      for (i = 0; i + 1 < len; i++)
         body.push_back(($urandom_range(0, 7) == 0) ? BarChar : 8'($urandom_range(0, 255)));
      if (code == CodeMsg) begin
         bars = 0;
         foreach (body[k]) if (body[k] == BarChar) bars++;
         if (bars < 2) begin
            i = $urandom_range(0, len - 2);
            j = $urandom_range(0, len - 3);
            if (j >= i) j++;
            body[i] = BarChar;
            body[j] = BarChar;
         end
      end
      body.push_back(BarChar);
      queue_byte(VersionChar);
      queue_byte(BarChar);
      queue_code(code);
      queue_byte(BarChar);
      queue_number(len, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0);
      queue_byte(BarChar);
      foreach (body[k]) queue_byte(body[k]);
      frames_ok++;
   endtask

   // Queue a frame that the block must reject; it stops the parser for good.
   task automatic queue_broken_frame(input break_kind_type kind);
      int unsigned lim;
      int unsigned len;
      int unsigned n;
      logic [23:0] code;
      logic [7:0]  b;
      lim  = (cur_limit < LenCap) ? cur_limit : LenCap;
      len  = $urandom_range(1, (lim < 8) ? lim : 8);
      code = (kind == BRK_FEW_FIELDS) ? CodeMsg : pick_code();
      // version field: empty, doubled or a wrong byte
      if (kind == BRK_VERSION) begin
         case ($urandom_range(0, 2))
            0: ;
            1: begin
               queue_byte(VersionChar);
               queue_byte(VersionChar);
            end
            default: begin
               b = any_but_bar();
               if (b == VersionChar) b = DigitZero;
               queue_byte(b);
            end
         endcase
      end else begin
         queue_byte(VersionChar);
      end
      queue_byte(BarChar);
      // code field: a wrong length, or three bytes led by a NUL
      if (kind == BRK_UNKNOWN_CODE) begin
         n = $urandom_range(0, 5);
         for (int i = 0; i < n; i++) queue_byte((i == 0 && n == 3) ? 8'h00 : any_but_bar());
      end else begin
         queue_code(code);
      end
      queue_byte(BarChar);
      case (kind)
         BRK_EMPTY_LEN: ;
         BRK_NONDIGIT: begin
            queue_number(len, 0);
            do b = any_but_bar(); while (b >= DigitZero && b <= DigitNine);
            queue_byte(b);
         end
         BRK_OVER_LIMIT: queue_number(lim + 1, $urandom_range(0, 2));
         BRK_ZERO_LEN:   queue_number(0, $urandom_range(0, 2));
         default:        queue_number(len, 0);
      endcase
      queue_byte(BarChar);
      // body; header errors never get this far
      for (int unsigned i = 0; i + 1 < len; i++) begin
         if (kind == BRK_FEW_FIELDS) b = any_but_bar();
         else b = 8'($urandom_range(0, 255));
         queue_byte(b);
      end
      if (kind == BRK_FEW_FIELDS && len >= 2 && $urandom_range(0, 1) == 1)
         tx_q[tx_q.size() - 1 - $urandom_range(0, len - 2)] = BarChar;
      queue_byte((kind == BRK_BAD_END) ? any_but_bar() : BarChar);
   endtask

   // Wait until every queued byte has made its transfer and no result is due,
   // then let the pipeline drain for bytes that cause no result.
   task automatic wait_idle();
      @(posedge clock);
      while (bytes_sent != bytes_queued || pending != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_limit(input logic [16:0] v);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      cur_limit  = v;
      limits_used++;
   endtask

   initial begin
      logic [16:0] setting;
      int          phase_start;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: SET with NUL and 0xFF bytes and a leading-zero length,
      // then MSG with one byte in each of the first two fields.
      queue_text("1|SET|03|");
      queue_byte(8'h00);
      queue_byte(8'hFF);
      queue_byte(BarChar);
      queue_text("1|MSG|5|a|b||");
      frames_ok += 2;

      // Random phases, each under its own length limit, the extremes among them.
      for (int p = 0; p < 6; p++) begin
         case (p)
            0:       setting = LenCap;
            1:       setting = 17'd1;
            2:       setting = 17'($urandom_range(3, 40));
            3:       setting = 17'($urandom_range(1, 99999));
            4:       setting = 17'd2;
            default: setting = 17'($urandom_range(3, 400));
         endcase
         wait_idle();
         write_limit(setting);
         phase_start = bytes_queued;
         if (p == 0) begin
            // long body while the receiver holds off: fill the result stage
            queue_good_frame(150);
            hold_go = 1'b1;
         end
         while (bytes_queued - phase_start < PhaseBytes) queue_good_frame(0);
      end

      // Close with a frame that stops the parser, then bytes it must ignore.
      wait_idle();
      brk = break_kind_type'($urandom_range(0, 7));
      queue_broken_frame(brk);
      repeat (12) queue_byte(8'($urandom_range(0, 255)));
      wait_idle();
      repeat (8) @(posedge clock);

      $display("Sent %0d bytes: %0d well-formed frames under %0d length settings,",
               bytes_sent, frames_ok, limits_used);
      $display("with sender gaps, receiver stalls, one long hold-off and a closing %s frame.",
               brk.name());
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

`default_nettype wire
